[hw/rtl/dpft_pkg.sv]
package dpft_pkg;

	localparam int CHAR_W  = 8;
	localparam int DIGIT_W = 4;
	localparam int WHOLE_W = 50;
	localparam int FRAC_W  = 14;
	localparam int CNT_W   = 3;
	localparam int TICKS_W = 63;
	localparam int PROD_W  = 64;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;

	// largest whole part that can still be scaled by 10000 without leaving 63 bits
	localparam logic [WHOLE_W-1:0] WHOLE_LIMIT  = 50'd922337203685477;
	localparam logic [FRAC_W-1:0]  TICK_SCALE   = 14'd10000;
	localparam logic [CNT_W-1:0]   KEPT_DIGITS  = 3'd4;
	localparam logic [CNT_W-1:0]   ROUND_POS    = 3'd5;
	localparam logic [DIGIT_W-1:0] ROUND_DIGIT  = 4'd5;

	// pad the kept fraction digits out to four places
	function automatic logic [FRAC_W-1:0] pad_fraction(input logic [FRAC_W-1:0] f,
			input logic [CNT_W-1:0] n);
		logic [FRAC_W-1:0] r;
		case (n)
			3'd0: r = '0;
			3'd1: r = f * 14'd1000;
			3'd2: r = f * 14'd100;
			3'd3: r = f * 14'd10;
			default: r = f;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/decimal_price_to_fixed_ticks.sv]
// Channel | Direction | Handshake             | Payload
// --------+-----------+-----------------------+---------------------------------
// in      | in        | in_valid / in_stall   | char_code[7:0], last_char
// out     | out       | out_valid / out_stall | ticks[62:0], valid_res
//
// One character is taken per cycle while in_stall is low; a transfer on out follows each
// character that carries last_char. Such a character passes from the input register
// through the parse state update and three result stages (rounding and carry, the two
// halves of the x10000 product, final add).
// arst_n clears all stage valids and the parse state; payload registers keep no reset.
// out_stall backs up through the stages into in_stall; characters that end no string
// only need the input register to move, so they are taken while a result waits.
module decimal_price_to_fixed_ticks (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dpft_pkg::CHAR_W-1:0]   char_code,
	input  logic                          last_char,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dpft_pkg::TICKS_W-1:0]  ticks,
	output logic                          valid_res
);
	import dpft_pkg::*;

	localparam int WMUL_W = WHOLE_W + DIGIT_W;

	// stage 1: input register
	logic                vld_s1;
	logic [CHAR_W-1:0]   char_s1;
	logic                last_s1;

	// parse state, lives across the characters of one string
	logic                in_frac_q;
	logic [WHOLE_W-1:0]  whole_q;
	logic                seen_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                round_q;
	logic                failed_q;
	logic                too_large_q;

	// state after the current character
	logic                in_frac_n;
	logic [WHOLE_W-1:0]  whole_n;
	logic                seen_n;
	logic [FRAC_W-1:0]   frac_n;
	logic [CNT_W-1:0]    cnt_n;
	logic                round_n;
	logic                failed_n;
	logic                too_large_n;

	logic                is_digit;
	logic [DIGIT_W-1:0]  digit;
	logic [WMUL_W-1:0]   whole_ext;
	logic [WMUL_W-1:0]   whole_mul;

	// stage 2: captured string end
	logic                vld_s2;
	logic [WHOLE_W-1:0]  whole_s2;
	logic [FRAC_W-1:0]   frac_s2;
	logic [CNT_W-1:0]    cnt_s2;
	logic                round_s2;
	logic                good_s2;

	logic [FRAC_W-1:0]   frac_pad;
	logic [FRAC_W-1:0]   frac_rnd;
	logic                carry;
	logic [FRAC_W-1:0]   frac_fin;
	logic [WHOLE_W-1:0]  whole_fin;

	// stage 3: rounded value
	logic                vld_s3;
	logic [WHOLE_W-1:0]  whole_s3;
	logic [FRAC_W-1:0]   frac_s3;
	logic                good_s3;

	logic [PROD_W-1:0]   w64;
	logic [PROD_W-1:0]   pa;
	logic [PROD_W-1:0]   pb;

	// stage 4: partial sums of whole * 10000 + frac
	logic                vld_s4;
	logic [PROD_W-1:0]   pa_s4;
	logic [PROD_W-1:0]   pb_s4;
	logic                good_s4;

	logic [PROD_W-1:0]   sum;
	logic                fits;

	// result register
	logic                out_valid_q;
	logic [TICKS_W-1:0]  ticks_q;
	logic                valid_res_q;

	logic rdy_out, rdy_s4, rdy_s3, rdy_s2, rdy_s1, adv_s1, end_s1;

	// ---- flow control ----
	assign rdy_out  = !out_valid_q || !out_stall;
	assign rdy_s4   = !vld_s4 || rdy_out;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	// only a string end needs room further down
	assign adv_s1   = vld_s1 && (!last_s1 || rdy_s2);
	assign end_s1   = adv_s1 && last_s1;
	assign rdy_s1   = !vld_s1 || adv_s1;
	assign in_stall = !rdy_s1;

	// ---- stage 1 ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	// ---- character parse ----
	assign is_digit  = (char_s1 >= CHAR_ZERO) && (char_s1 <= CHAR_NINE);
	assign digit     = char_s1[DIGIT_W-1:0];   // '0'..'9' have the digit in the low nibble
	assign whole_ext = {{DIGIT_W{1'b0}}, whole_q};
	assign whole_mul = (whole_ext << 3) + (whole_ext << 1)
		+ {{WHOLE_W{1'b0}}, digit};

	always_comb begin
		in_frac_n   = in_frac_q;
		whole_n     = whole_q;
		seen_n      = seen_q;
		frac_n      = frac_q;
		cnt_n       = cnt_q;
		round_n     = round_q;
		failed_n    = failed_q;
		too_large_n = too_large_q;
		if (!in_frac_q) begin
			if (is_digit) begin
				seen_n = 1'b1;
				if (!too_large_q) begin
					if (whole_mul > {{DIGIT_W{1'b0}}, WHOLE_LIMIT}) begin
						too_large_n = 1'b1;   // sticky, whole part frozen
					end else begin
						whole_n = whole_mul[WHOLE_W-1:0];
					end
				end
			end else if (char_s1 == CHAR_POINT) begin
				in_frac_n = 1'b1;
			end else begin
				failed_n = 1'b1;
			end
		end else if (!is_digit) begin
			failed_n = 1'b1;
		end else if (cnt_q < KEPT_DIGITS) begin
			frac_n = (frac_q << 3) + (frac_q << 1) + {{(FRAC_W-DIGIT_W){1'b0}}, digit};
			cnt_n  = cnt_q + 3'd1;
		end else if (cnt_q == KEPT_DIGITS) begin
			round_n = (digit >= ROUND_DIGIT);
			cnt_n   = ROUND_POS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frac_q   <= 1'b0;
			whole_q     <= '0;
			seen_q      <= 1'b0;
			frac_q      <= '0;
			cnt_q       <= '0;
			round_q     <= 1'b0;
			failed_q    <= 1'b0;
			too_large_q <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				in_frac_q   <= 1'b0;
				whole_q     <= '0;
				seen_q      <= 1'b0;
				frac_q      <= '0;
				cnt_q       <= '0;
				round_q     <= 1'b0;
				failed_q    <= 1'b0;
				too_large_q <= 1'b0;
			end else begin
				in_frac_q   <= in_frac_n;
				whole_q     <= whole_n;
				seen_q      <= seen_n;
				frac_q      <= frac_n;
				cnt_q       <= cnt_n;
				round_q     <= round_n;
				failed_q    <= failed_n;
				too_large_q <= too_large_n;
			end
		end
	end

	// ---- stage 2: string end captured ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= end_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (end_s1) begin
			whole_s2 <= whole_n;
			frac_s2  <= frac_n;
			cnt_s2   <= cnt_n;
			round_s2 <= round_n;
			good_s2  <= !failed_n && !too_large_n && seen_n;
		end
	end

	// pad, round, carry into the whole part
	assign frac_pad  = pad_fraction(frac_s2, cnt_s2);
	assign frac_rnd  = frac_pad + {{(FRAC_W-1){1'b0}}, round_s2};
	assign carry     = (frac_rnd == TICK_SCALE);
	assign frac_fin  = carry ? '0 : frac_rnd;
	assign whole_fin = whole_s2 + {{(WHOLE_W-1){1'b0}}, carry};

	// ---- stage 3 ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2 && rdy_s3) begin
			whole_s3 <= whole_fin;
			frac_s3  <= frac_fin;
			good_s3  <= good_s2;
		end
	end

	// 10000 = 8192 + 1024 + 512 + 256 + 16, split into two partial sums
	assign w64 = {{(PROD_W-WHOLE_W){1'b0}}, whole_s3};
	assign pa  = (w64 << 13) + (w64 << 10);
	assign pb  = (w64 << 9) + (w64 << 8) + (w64 << 4)
		+ {{(PROD_W-FRAC_W){1'b0}}, frac_s3};

	// ---- stage 4 ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (rdy_s4) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s3 && rdy_s4) begin
			pa_s4   <= pa;
			pb_s4   <= pb;
			good_s4 <= good_s3;
		end
	end

	// whole is below 2^50, so the sum never wraps 64 bits; bit 63 set means no fit
	assign sum  = pa_s4 + pb_s4;
	assign fits = good_s4 && !sum[PROD_W-1];

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s4 && rdy_out) begin
			ticks_q     <= fits ? sum[TICKS_W-1:0] : '0;
			valid_res_q <= fits;
		end
	end

	assign out_valid = out_valid_q;
	assign ticks     = ticks_q;
	assign valid_res = valid_res_q;

endmodule

[test/decimal_price_to_fixed_ticks_tb.sv]
module decimal_price_to_fixed_ticks_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dpft_pkg::*;

	// largest value a signed 64-bit tick count can hold
	localparam logic [63:0] TICKS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	// parse state of the price being collected, mirrored from the block's behaviour
	typedef struct packed {
		logic                in_fraction;
		logic [WHOLE_W-1:0]  whole_value;
		logic                whole_seen;
		logic [FRAC_W-1:0]   frac_value;
		logic [CNT_W-1:0]    frac_count;
		logic                round_up;
		logic                failed;
		logic                too_large;
	} parse_state_t;

	typedef struct packed {
		logic [TICKS_W-1:0] ticks;
		logic               valid_res;
	} price_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [CHAR_W-1:0]   char_code = '0;
	logic                last_char = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [TICKS_W-1:0]  ticks;
	logic                valid_res;

	parse_state_t        parse_st = '0;
	price_t              pending_prices[$];   // expected results, oldest first
	logic [CHAR_W-1:0]   price_chars[$];      // string being built for sending
	int                  chars_sent = 0;
	int                  fault_count = 0;
	bit                  idle_on = 1'b1;      // random gaps on both sides
	int                  hold_len = 0;        // request for one long receiver hold-off

	decimal_price_to_fixed_ticks dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.last_char (last_char),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ticks     (ticks),
		.valid_res (valid_res)
	);

	always #5 clk = ~clk;

	// Add one character to the end of the string being built.
	function automatic void append_char(input logic [CHAR_W-1:0] c);
		price_chars.insert(price_chars.size(), c);
	endfunction

	// Fold one accepted character into the parse state; on the last character of a
	// string, work out the price in ticks and queue it, then start afresh.
	function automatic void track_char(input logic [CHAR_W-1:0] c, input logic last);
		logic        is_digit;
		logic [63:0] d;
		logic [63:0] nxt;
		logic [63:0] whole;
		logic [63:0] frac;
		int          k;
		price_t      res;
		is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
		d = 64'(c) - 64'(CHAR_ZERO);
		if (!parse_st.in_fraction) begin
			if (is_digit) begin
				parse_st.whole_seen = 1'b1;
				// once too large the accumulator freezes
				if (!parse_st.too_large) begin
					nxt = 64'(parse_st.whole_value) * 64'd10 + d;
					if (nxt > 64'(WHOLE_LIMIT))
						parse_st.too_large = 1'b1;
					else
						parse_st.whole_value = nxt[WHOLE_W-1:0];
				end
			end else if (c == CHAR_POINT) begin
				parse_st.in_fraction = 1'b1;
			end else begin
				parse_st.failed = 1'b1;   // sign, letter, control code...
			end
		end else if (!is_digit) begin
			parse_st.failed = 1'b1;       // includes a second point
		end else if (parse_st.frac_count < KEPT_DIGITS) begin
			parse_st.frac_value = FRAC_W'(64'(parse_st.frac_value) * 64'd10 + d);
			parse_st.frac_count = parse_st.frac_count + 1'b1;
		end else if (parse_st.frac_count == KEPT_DIGITS) begin
			// fifth fraction digit only decides rounding; later ones are dropped
			parse_st.round_up = (d[DIGIT_W-1:0] >= ROUND_DIGIT);
			parse_st.frac_count = ROUND_POS;
		end
		if (!last)
			return;
		res = '0;
		if (!parse_st.failed && !parse_st.too_large && parse_st.whole_seen) begin
			whole = 64'(parse_st.whole_value);
			frac = 64'(parse_st.frac_value);
			for (k = int'(parse_st.frac_count); k < int'(KEPT_DIGITS); k++)
				frac = frac * 64'd10;
			if (parse_st.round_up) begin
				frac = frac + 64'd1;
				if (frac == 64'(TICK_SCALE)) begin
					frac = '0;
					whole = whole + 64'd1;   // carry into the whole part
				end
			end
			// fit check is made on the carried value
			if (whole <= (TICKS_MAX - frac) / 64'(TICK_SCALE)) begin
				res.ticks = TICKS_W'(whole * 64'(TICK_SCALE) + frac);
				res.valid_res = 1'b1;
			end
		end
		pending_prices.insert(pending_prices.size(), res);
		parse_st = '0;
	endfunction

	// One character transfer on the input channel. Valid stays up after the transfer
	// unless a gap is drawn, so back-to-back characters need no extra edge.
	task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
		in_valid <= 1'b1;
		char_code <= c;
		last_char <= last;
		do @(posedge clk); while (in_stall);
		track_char(c, last);
		chars_sent++;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// Send the built string, marking its final character.
	task automatic send_price();
		int i;
		for (i = 0; i < price_chars.size(); i++)
			send_char(price_chars[i], i == price_chars.size() - 1);
		price_chars.delete();
	endtask

	function automatic void put_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			append_char(s[i]);
	endfunction

	function automatic void put_digits(input int n);
		int i;
		for (i = 0; i < n; i++)
			append_char(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
	endfunction

	// Plain price: mostly short whole parts, sometimes long ones or leading zeros.
	function automatic void build_well_formed();
		int i;
		if ($urandom_range(0, 9) == 0)
			for (i = 0; i < $urandom_range(1, 6); i++)
				append_char(CHAR_ZERO);
		if ($urandom_range(0, 3) == 0)
			put_digits($urandom_range(1, 16));
		else
			put_digits($urandom_range(1, 4));
		if ($urandom_range(0, 9) < 7) begin
			append_char(CHAR_POINT);
			put_digits($urandom_range(0, 8));
		end
	endfunction

	// Prices around the largest value that still fits once scaled.
	function automatic void build_near_limit();
		case ($urandom_range(0, 4))
			0: put_text("922337203685477");
			1: put_text("922337203685476");
			2: put_text("922337203685478");
			3: put_text("9223372036854775");
			default: put_text("99999999999999");
		endcase
		case ($urandom_range(0, 7))
			0: ;
			1: put_text(".5807");
			2: put_text(".5808");
			3: put_text(".58074");
			4: put_text(".58075");
			5: put_text(".99995");
			6: put_text(".9999");
			default: begin
				append_char(CHAR_POINT);
				put_digits($urandom_range(1, 7));
			end
		endcase
	endfunction

	function automatic void build_broken();
		case ($urandom_range(0, 3))
			0: begin
				append_char($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
				build_well_formed();
			end
			1: begin
				// one character swapped for any byte, which may still be a digit
				build_well_formed();
				price_chars[$urandom_range(0, price_chars.size() - 1)] =
					CHAR_W'($urandom_range(0, 255));
			end
			2: begin
				put_digits($urandom_range(1, 3));
				append_char(CHAR_POINT);
				put_digits($urandom_range(0, 2));
				append_char(CHAR_POINT);
				put_digits($urandom_range(0, 3));
			end
			default: begin
				append_char(CHAR_POINT);   // no whole part
				put_digits($urandom_range(0, 5));
			end
		endcase
	endfunction

	function automatic void build_noise();
		int i;
		for (i = 0; i < $urandom_range(1, 6); i++)
			append_char(CHAR_W'($urandom_range(0, 255)));
	endfunction

	function automatic void build_random_price();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			build_well_formed();
		else if (pick < 70)
			build_near_limit();
		else if (pick < 88)
			build_broken();
		else
			build_noise();
	endfunction

	// Short hand-picked strings: extremes of the character code, a sign, a leading
	// point, a trailing point, a double point, a rounding carry and spare digits.
	task automatic test_directed_cases();
		put_text("0");        send_price();
		put_text("5.");       send_price();
		put_text(".5");       send_price();
		put_text("-3");       send_price();
		put_text("1..2");     send_price();
		put_text("0.99995");  send_price();
		put_text("2.345678"); send_price();
		append_char(8'hFF); send_price();
		append_char(8'h00); send_price();
	endtask

	task automatic test_mixed_prices(input int char_goal);
		while (chars_sent < char_goal) begin
			build_random_price();
			send_price();
		end
	endtask

	// Receiver holds off for a long stretch while short prices keep coming, so the
	// result stages fill and the input channel stalls.
	task automatic test_full_pipeline();
		int i;
		idle_on = 1'b0;
		hold_len = 80;
		for (i = 0; i < 30; i++) begin
			put_digits($urandom_range(1, 2));
			send_price();
		end
		idle_on = 1'b1;
	endtask

	// Sender waits for every outstanding result before carrying on.
	task automatic test_drain_pause();
		int r;
		int i;
		for (r = 0; r < 4; r++) begin
			for (i = 0; i < 3; i++) begin
				build_random_price();
				send_price();
			end
			in_valid <= 1'b0;
			do @(posedge clk); while (pending_prices.size() != 0);
		end
	endtask

	// Closing stretch with no gaps on either side.
	task automatic test_steady_stream(input int char_goal);
		idle_on = 1'b0;
		test_mixed_prices(char_goal);
	endtask

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", msg);
	endtask

	// Result checker: every output transfer against the oldest expectation.
	always @(posedge clk) begin : check_prices
		price_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_prices.size() == 0) begin
				note_fault($sformatf("%0t: unexpected result ticks=%0d valid_res=%0b",
					$realtime, ticks, valid_res));
			end else begin
				want = pending_prices.pop_front();
				if (ticks !== want.ticks || valid_res !== want.valid_res)
					note_fault($sformatf({"%0t: price mismatch, expected ticks=%0d ",
						"valid_res=%0b, got ticks=%0d valid_res=%0b"}, $realtime,
						want.ticks, want.valid_res, ticks, valid_res));
			end
		end
	end

	// Output stall: random bursts, idle-free stretches, and one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				out_stall <= 1'b1;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_stall <= 1'b0;
			end else if (idle_on) begin
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	// Sequence of tests, then drain and verdict
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_mixed_prices(600);
		test_full_pipeline();
		test_drain_pause();
		test_mixed_prices(1000);
		test_steady_stream(1200);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_prices.size() != 0);
		// wait on a while longer to catch any stray result
		repeat (12) @(posedge clk);
		if (fault_count == 0 && pending_prices.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run
	initial begin
		#3000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
